[design/blr_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the Bresenham line rasterizer.
// No dependencies; used by every module of the block.
package blr_pkg;

  // Command codes on the func field
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  // Color width (three 8-bit channels)
  localparam int COLOR_BITS = 24;

  // Step direction codes, two-bit signed
  localparam logic signed [1:0] DIR_NONE = 2'sb00;
  localparam logic signed [1:0] DIR_POS  = 2'sb01;
  localparam logic signed [1:0] DIR_NEG  = 2'sb11;

  // Direction and major-axis flags of the active line
  typedef struct packed {
    logic signed [1:0] dir_x;
    logic signed [1:0] dir_y;
    logic              x_major;
  } line_ctl_t;

endpackage

[design/blr_setup.sv]
`timescale 1ns / 1ps
// Line setup: deltas, step directions, major axis, initial error and pixel count.
// Depends on blr_pkg.
module blr_setup #(
  parameter int COORD_BITS = 12
) (
  input  logic [COORD_BITS-1:0]          start_x,
  input  logic [COORD_BITS-1:0]          start_y,
  input  logic [COORD_BITS-1:0]          end_x,
  input  logic [COORD_BITS-1:0]          end_y,
  output logic [COORD_BITS-1:0]          abs_dx,
  output logic [COORD_BITS-1:0]          abs_dy,
  output blr_pkg::line_ctl_t             ctl,
  output logic signed [COORD_BITS+2:0]   error_init,
  output logic [COORD_BITS:0]            count_init
);

  localparam int ErrBits = COORD_BITS + 3;

  logic [COORD_BITS-1:0] major;
  logic [COORD_BITS-1:0] minor;

  // Per-axis magnitude and direction
  always_comb begin
    if (end_x > start_x) begin
      abs_dx    = end_x - start_x;
      ctl.dir_x = blr_pkg::DIR_POS;
    end else if (end_x < start_x) begin
      abs_dx    = start_x - end_x;
      ctl.dir_x = blr_pkg::DIR_NEG;
    end else begin
      abs_dx    = '0;
      ctl.dir_x = blr_pkg::DIR_NONE;
    end
    if (end_y > start_y) begin
      abs_dy    = end_y - start_y;
      ctl.dir_y = blr_pkg::DIR_POS;
    end else if (end_y < start_y) begin
      abs_dy    = start_y - end_y;
      ctl.dir_y = blr_pkg::DIR_NEG;
    end else begin
      abs_dy    = '0;
      ctl.dir_y = blr_pkg::DIR_NONE;
    end
    // Major axis is x on ties
    ctl.x_major = (abs_dx >= abs_dy);
  end

  assign major       = ctl.x_major ? abs_dx : abs_dy;
  assign minor       = ctl.x_major ? abs_dy : abs_dx;

  // Error starts at 2*minor - major; a line of length L has L+1 pixels
  assign error_init = (ErrBits'(minor) << 1) - ErrBits'(major);
  assign count_init = {1'b0, major} + (COORD_BITS+1)'(1);

endmodule

[design/blr_step.sv]
`timescale 1ns / 1ps
// One Bresenham step: next pixel position and next error term.
// Depends on blr_pkg.
module blr_step #(
  parameter int COORD_BITS = 12
) (
  input  logic [COORD_BITS-1:0]          cur_x,
  input  logic [COORD_BITS-1:0]          cur_y,
  input  logic signed [COORD_BITS+2:0]   error_term,
  input  logic [COORD_BITS-1:0]          abs_dx,
  input  logic [COORD_BITS-1:0]          abs_dy,
  input  blr_pkg::line_ctl_t             ctl,
  output logic [COORD_BITS-1:0]          next_x,
  output logic [COORD_BITS-1:0]          next_y,
  output logic signed [COORD_BITS+2:0]   next_error
);

  localparam int ErrBits = COORD_BITS + 3;

  // Move one unit in the given direction, wrapping within the coordinate width
  function automatic logic [COORD_BITS-1:0] move_coord(input logic [COORD_BITS-1:0] c,
                                                       input logic signed [1:0] d);
    logic [COORD_BITS-1:0] r;
    r = c;
    if (d == blr_pkg::DIR_POS) begin
      r = c + COORD_BITS'(1);
    end else if (d == blr_pkg::DIR_NEG) begin
      r = c - COORD_BITS'(1);
    end
    return r;
  endfunction

  logic                        minor_neg;
  logic                        take;
  logic [ErrBits-1:0]          two_maj;
  logic [ErrBits-1:0]          two_min;
  logic signed [ErrBits-1:0]   err_adj;
  logic [COORD_BITS-1:0]       x_minor;
  logic [COORD_BITS-1:0]       y_minor;

  // Tie rule: strict compare when the minor axis runs negative
  assign minor_neg = ctl.x_major ? (ctl.dir_y == blr_pkg::DIR_NEG)
                                 : (ctl.dir_x == blr_pkg::DIR_NEG);
  assign take      = minor_neg ? (error_term > 0) : (error_term >= 0);

  assign two_maj = (ctl.x_major ? ErrBits'(abs_dx) : ErrBits'(abs_dy)) << 1;
  assign two_min = (ctl.x_major ? ErrBits'(abs_dy) : ErrBits'(abs_dx)) << 1;

  // Minor-axis move first, then the major-axis move
  always_comb begin
    x_minor = cur_x;
    y_minor = cur_y;
    err_adj = error_term;
    if (take) begin
      if (ctl.x_major) begin
        y_minor = move_coord(cur_y, ctl.dir_y);
      end else begin
        x_minor = move_coord(cur_x, ctl.dir_x);
      end
      err_adj = error_term - two_maj;
    end
    if (ctl.x_major) begin
      next_x = move_coord(x_minor, ctl.dir_x);
      next_y = y_minor;
    end else begin
      next_x = x_minor;
      next_y = move_coord(y_minor, ctl.dir_y);
    end
    next_error = err_adj + two_min;
  end

endmodule

[design/bresenham_line_rasterizer.sv]
`timescale 1ns / 1ps
// Bresenham line rasterizer, all octants, one command per clock when not stalled.
// A command is captured in the input register at its transfer edge; a step's pixel
// goes to the result register when the command leaves the input register.
// Throughput: one command per cycle while no stalled result blocks the input register.
// Reset (rst, synchronous, active high) empties both registers and leaves the line idle.
module bresenham_line_rasterizer #(
  parameter int COORD_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  // command channel
  input  logic                            cmd_valid,
  output logic                            cmd_stall,
  input  logic                            func,
  input  logic [COORD_BITS-1:0]           start_x,
  input  logic [COORD_BITS-1:0]           start_y,
  input  logic [COORD_BITS-1:0]           end_x,
  input  logic [COORD_BITS-1:0]           end_y,
  input  logic [blr_pkg::COLOR_BITS-1:0]  color_in,
  // pixel channel
  output logic                            pix_valid,
  input  logic                            pix_stall,
  output logic [COORD_BITS-1:0]           pixel_x,
  output logic [COORD_BITS-1:0]           pixel_y,
  output logic [blr_pkg::COLOR_BITS-1:0]  color_out,
  output logic                            last
);

  localparam int ErrBits = COORD_BITS + 3;

  // Input register
  logic                            s1_valid;
  logic                            s1_func;
  logic [COORD_BITS-1:0]           s1_sx;
  logic [COORD_BITS-1:0]           s1_sy;
  logic [COORD_BITS-1:0]           s1_ex;
  logic [COORD_BITS-1:0]           s1_ey;
  logic [blr_pkg::COLOR_BITS-1:0]  s1_color;

  // Line state
  logic [COORD_BITS-1:0]           cur_x;
  logic [COORD_BITS-1:0]           cur_y;
  logic signed [ErrBits-1:0]       error_term;
  logic [COORD_BITS:0]             pixels_left;
  logic [COORD_BITS-1:0]           abs_dx;
  logic [COORD_BITS-1:0]           abs_dy;
  blr_pkg::line_ctl_t              ctl;
  logic [blr_pkg::COLOR_BITS-1:0]  line_color;
  logic                            busy;

  // Setup and step results
  logic [COORD_BITS-1:0]           init_dx;
  logic [COORD_BITS-1:0]           init_dy;
  blr_pkg::line_ctl_t              init_ctl;
  logic signed [ErrBits-1:0]       init_error;
  logic [COORD_BITS:0]             init_count;
  logic [COORD_BITS-1:0]           x_next;
  logic [COORD_BITS-1:0]           y_next;
  logic signed [ErrBits-1:0]       error_next;
  logic [COORD_BITS:0]             pixels_left_next;

  logic advance;
  logic take_cmd;
  logic fire;
  logic emit;

  blr_setup #(.COORD_BITS(COORD_BITS)) u_setup (
    .start_x    (s1_sx),
    .start_y    (s1_sy),
    .end_x      (s1_ex),
    .end_y      (s1_ey),
    .abs_dx     (init_dx),
    .abs_dy     (init_dy),
    .ctl        (init_ctl),
    .error_init (init_error),
    .count_init (init_count)
  );

  blr_step #(.COORD_BITS(COORD_BITS)) u_step (
    .cur_x      (cur_x),
    .cur_y      (cur_y),
    .error_term (error_term),
    .abs_dx     (abs_dx),
    .abs_dy     (abs_dy),
    .ctl        (ctl),
    .next_x     (x_next),
    .next_y     (y_next),
    .next_error (error_next)
  );

  // Handshake: the result register frees up when empty or being taken
  assign advance   = !pix_valid || !pix_stall;
  assign cmd_stall = s1_valid && !advance;
  assign take_cmd  = cmd_valid && !cmd_stall;
  assign fire      = s1_valid && advance;
  assign emit      = fire && (s1_func == blr_pkg::FUNC_STEP) && busy;

  assign pixels_left_next = pixels_left - (COORD_BITS+1)'(1);

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!cmd_stall) begin
      s1_valid <= cmd_valid;
    end
    if (take_cmd) begin
      s1_func  <= func;
      s1_sx    <= start_x;
      s1_sy    <= start_y;
      s1_ex    <= end_x;
      s1_ey    <= end_y;
      s1_color <= color_in;
    end
  end

  // Line state update
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x       <= '0;
      cur_y       <= '0;
      error_term  <= '0;
      pixels_left <= '0;
      abs_dx      <= '0;
      abs_dy      <= '0;
      ctl         <= '0;
      line_color  <= '0;
      busy        <= 1'b0;
    end else if (fire && (s1_func == blr_pkg::FUNC_START)) begin
      cur_x       <= s1_sx;
      cur_y       <= s1_sy;
      error_term  <= init_error;
      pixels_left <= init_count;
      abs_dx      <= init_dx;
      abs_dy      <= init_dy;
      ctl         <= init_ctl;
      line_color  <= s1_color;
      busy        <= 1'b1;
    end else if (emit) begin
      cur_x       <= x_next;
      cur_y       <= y_next;
      error_term  <= error_next;
      pixels_left <= pixels_left_next;
      busy        <= (pixels_left_next != '0);
    end
  end

  // Result register; color goes out with channels 0 and 2 swapped
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (advance) begin
      pix_valid <= emit;
    end
    if (emit) begin
      pixel_x   <= cur_x;
      pixel_y   <= cur_y;
      color_out <= {line_color[7:0], line_color[15:8], line_color[23:16]};
      last      <= (pixels_left == (COORD_BITS+1)'(1));
    end
  end

  // The final pixel of a line leaves the block idle
  a_last_idles: assert property (@(posedge clk) disable iff (rst)
    (emit && pixels_left == (COORD_BITS+1)'(1)) |=> !busy)
    else $error("line still busy after its final pixel");

  // An active line always has pixels left to give
  a_busy_count: assert property (@(posedge clk) disable iff (rst)
    busy |-> (pixels_left != '0))
    else $error("busy with zero pixels left");

  // A new result only follows a step taken on an active line
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(pix_valid) |-> $past(emit))
    else $error("pixel result without a step");

  // The command channel only stalls while the input register holds a command
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> (s1_valid && pix_valid && pix_stall))
    else $error("command stall without a blocked result");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// Testbench for bresenham_line_rasterizer: directed lines, random line streams and noise,
// checked pixel by pixel against a line predictor. Depends on blr_pkg and the block RTL.

localparam int CB = 12;

typedef struct {
  logic [CB-1:0] x;
  logic [CB-1:0] y;
  logic [23:0]   color;
  logic          last;
} pixel_t;

// Tracks the line state and holds the pixels the block still owes
class line_pixel_predictor;
  logic [CB-1:0]     cur_x, cur_y;
  int                err;
  logic [CB:0]       pixels_left;
  logic [CB-1:0]     span_x, span_y;
  logic signed [1:0] dir_x, dir_y;
  bit                x_major;
  logic [23:0]       line_color;
  bit                busy;
  pixel_t            expected_pixels[$];
  int                mismatches;

  function new();
    cur_x = '0; cur_y = '0; err = 0; pixels_left = '0;
    span_x = '0; span_y = '0; dir_x = blr_pkg::DIR_NONE; dir_y = blr_pkg::DIR_NONE;
    x_major = 0; line_color = '0; busy = 0; mismatches = 0;
  endfunction

  function void axis_span(input logic [CB-1:0] a, input logic [CB-1:0] b,
                          output logic [CB-1:0] mag, output logic signed [1:0] dir);
    if (b > a) begin
      mag = b - a; dir = blr_pkg::DIR_POS;
    end else if (b < a) begin
      mag = a - b; dir = blr_pkg::DIR_NEG;
    end else begin
      mag = '0; dir = blr_pkg::DIR_NONE;
    end
  endfunction

  // one unit along an axis, wrapping within the coordinate width
  function logic [CB-1:0] step_coord(logic [CB-1:0] c, logic signed [1:0] d);
    if (d == blr_pkg::DIR_POS) return c + 1'b1;
    if (d == blr_pkg::DIR_NEG) return c - 1'b1;
    return c;
  endfunction

  // Returns 1 when the command has an effect (a step while idle has none)
  function bit note_command(logic f, logic [CB-1:0] sx, logic [CB-1:0] sy,
                            logic [CB-1:0] ex, logic [CB-1:0] ey, logic [23:0] col);
    pixel_t            px;
    bit                take;
    logic signed [1:0] minor_dir;
    int                span_major, span_minor;
    if (f == blr_pkg::FUNC_START) begin
      axis_span(sx, ex, span_x, dir_x);
      axis_span(sy, ey, span_y, dir_y);
      cur_x = sx;
      cur_y = sy;
      x_major = span_x >= span_y;
      span_major = x_major ? int'(span_x) : int'(span_y);
      span_minor = x_major ? int'(span_y) : int'(span_x);
      err = 2 * span_minor - span_major;
      pixels_left = (CB+1)'(span_major + 1);
      line_color = col;
      busy = 1;
      return 1;
    end
    if (!busy) return 0;

    px.x = cur_x;
    px.y = cur_y;
    px.color = {line_color[7:0], line_color[15:8], line_color[23:16]};
    px.last = (pixels_left == 1);
    expected_pixels.push_back(px);

    // advance; a negative minor axis steps only on a strictly positive error
    span_major = x_major ? int'(span_x) : int'(span_y);
    span_minor = x_major ? int'(span_y) : int'(span_x);
    minor_dir = x_major ? dir_y : dir_x;
    take = (minor_dir == blr_pkg::DIR_NEG) ? (err > 0) : (err >= 0);
    if (take) begin
      if (x_major) cur_y = step_coord(cur_y, dir_y);
      else cur_x = step_coord(cur_x, dir_x);
      err -= 2 * span_major;
    end
    if (x_major) cur_x = step_coord(cur_x, dir_x);
    else cur_y = step_coord(cur_y, dir_y);
    err += 2 * span_minor;
    pixels_left = pixels_left - 1'b1;
    if (pixels_left == 0) busy = 0;
    return 1;
  endfunction

  function void check_pixel(logic [CB-1:0] x, logic [CB-1:0] y, logic [23:0] c, logic l);
    pixel_t e;
    if (expected_pixels.size() == 0) begin
      $error("pixel with none expected: x=%0d y=%0d", x, y);
      mismatches++;
      return;
    end
    e = expected_pixels.pop_front();
    if (x !== e.x) begin
      $error("pixel_x: expected %0d, actual %0d", e.x, x);
      mismatches++;
    end
    if (y !== e.y) begin
      $error("pixel_y: expected %0d, actual %0d", e.y, y);
      mismatches++;
    end
    if (c !== e.color) begin
      $error("color_out: expected %06h, actual %06h", e.color, c);
      mismatches++;
    end
    if (l !== e.last) begin
      $error("last: expected %0b, actual %0b", e.last, l);
      mismatches++;
    end
  endfunction
endclass

module testbench;
  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cmd_valid = 1'b0;
  logic          cmd_stall;
  logic          func = blr_pkg::FUNC_START;
  logic [CB-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
  logic [23:0]   color_in = '0;
  logic          pix_valid;
  logic          pix_stall = 1'b0;
  logic [CB-1:0] pixel_x, pixel_y;
  logic [23:0]   color_out;
  logic          last;

  line_pixel_predictor line_model = new();

  int accepted_items = 0;
  int burst_left = 5;
  bit steady = 0;
  bit hold_req = 0;
  bit hold_done = 0;
  bit pause_done = 0;

  bresenham_line_rasterizer #(.COORD_BITS(CB)) u_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Pixel side: stall pattern changes mode now and then; a requested hold-off
  // keeps stall high for a long stretch
  initial begin
    int mode, mode_left, hold_left;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold_left = 400;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        pix_stall <= 1'b1;
      end else begin
        case (mode)
          0: pix_stall <= 1'b0;
          1: pix_stall <= ($urandom_range(0, 3) == 0);
          2: pix_stall <= ($urandom_range(0, 3) != 0);
          default: pix_stall <= mode_left[0];
        endcase
      end
    end
  end

  // Pixel monitor
  always @(posedge clk) begin
    if (!rst && pix_valid === 1'b1 && pix_stall == 1'b0)
      line_model.check_pixel(pixel_x, pixel_y, color_out, last);
  end

  // One command transfer; entered and left at a falling edge. Bursts end in a
  // random gap unless the sender is in a steady stretch.
  task automatic send_cmd(logic f, logic [CB-1:0] sx, logic [CB-1:0] sy,
                          logic [CB-1:0] ex, logic [CB-1:0] ey, logic [23:0] col);
    func <= f;
    start_x <= sx;
    start_y <= sy;
    end_x <= ex;
    end_y <= ey;
    color_in <= col;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall !== 1'b0);
    void'(line_model.note_command(f, sx, sy, ex, ey, col));
    accepted_items++;
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 30);
      if (!steady) begin
        cmd_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  endtask

  // Step with junk in the ignored fields
  task automatic send_step();
    send_cmd(blr_pkg::FUNC_STEP, CB'($urandom_range(0, 4095)), CB'($urandom_range(0, 4095)),
             CB'($urandom_range(0, 4095)), CB'($urandom_range(0, 4095)),
             24'($urandom_range(0, 24'hFFFFFF)));
  endtask

  task automatic draw_line(int sx, int sy, int ex, int ey, int steps);
    send_cmd(blr_pkg::FUNC_START, CB'(sx), CB'(sy), CB'(ex), CB'(ey),
             24'($urandom_range(0, 24'hFFFFFF)));
    repeat (steps) send_step();
  endtask

  // Sender pauses until every owed pixel has been taken
  task automatic wait_drained();
    cmd_valid <= 1'b0;
    while (line_model.expected_pixels.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic int near_end(int s, int d);
    int e;
    e = $urandom_range(0, 1) ? s + d : s - d;
    if (e > 4095) e = s - d;
    if (e < 0) e = s + d;
    return e;
  endfunction

  // Mostly short lines; some cut short by the next start, some overrun into idle steps
  task automatic random_line();
    int sx, sy, ex, ey, maxd, len, steps, r;
    r = $urandom_range(0, 99);
    maxd = (r < 70) ? 12 : (r < 95) ? 40 : 200;
    sx = $urandom_range(0, 4095);
    sy = $urandom_range(0, 4095);
    ex = near_end(sx, $urandom_range(0, maxd));
    ey = near_end(sy, $urandom_range(0, maxd));
    len = (ex > sx) ? ex - sx : sx - ex;
    if (((ey > sy) ? ey - sy : sy - ey) > len) len = (ey > sy) ? ey - sy : sy - ey;
    steps = len + 1;
    r = $urandom_range(0, 99);
    if (r < 10) steps = $urandom_range(0, len);
    else if (r < 20) steps = len + 1 + $urandom_range(1, 3);
    draw_line(sx, sy, ex, ey, steps);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: idle step, zero-length line, full-range diagonal replaced
    // while busy, lines at the coordinate edge, the strict tie rule, steep negative line
    send_cmd(blr_pkg::FUNC_STEP, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 24'hFFFFFF);
    send_cmd(blr_pkg::FUNC_START, 12'd5, 12'd5, 12'd5, 12'd5, 24'h123456);
    send_step();
    send_step();
    send_cmd(blr_pkg::FUNC_START, 12'd0, 12'd0, 12'd4095, 12'd4095, 24'hFFFFFF);
    repeat (3) send_step();
    send_cmd(blr_pkg::FUNC_START, 12'd4095, 12'd0, 12'd0, 12'd4095, 24'h000000);
    repeat (2) send_step();
    draw_line(4093, 4095, 4095, 4094, 3);
    draw_line(2, 1, 0, 0, 3);
    draw_line(1, 0, 0, 2, 3);
    draw_line(0, 4095, 2, 4095, 4);
    wait_drained();

    // Random lines and noise
    while (accepted_items < 940) begin
      if (!hold_done && accepted_items > 350) begin
        hold_done = 1;
        hold_req = 1;
        draw_line(100, 200, 180, 230, 81);
      end else if (!pause_done && accepted_items > 650) begin
        pause_done = 1;
        wait_drained();
      end else if ($urandom_range(0, 99) < 85) begin
        random_line();
      end else begin
        send_cmd(1'($urandom_range(0, 1)), CB'($urandom_range(0, 4095)),
                 CB'($urandom_range(0, 4095)), CB'($urandom_range(0, 4095)),
                 CB'($urandom_range(0, 4095)), 24'($urandom_range(0, 24'hFFFFFF)));
      end
      if ($urandom_range(0, 14) == 0) steady = !steady;
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (line_model.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
